### hdl/fkh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkh_pkg
// Shared types and constants for the IPv4 flow key hash block.
// ----------------------------------------------------------------------------
package fkh_pkg;

  localparam logic [3:0] KEY_LEN_NONE  = 4'd0;
  localparam logic [3:0] KEY_LEN_PAIR  = 4'd8;
  localparam logic [3:0] KEY_LEN_TUPLE = 4'd13;

  // key captured at frame end; key_len of zero means the result is 0
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    logic [7:0]  proto;
    logic [3:0]  key_len;
  } fkh_key_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fkh_queue_status_t;

endpackage

### hdl/fkh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkh_front
// Frame byte parser: counts bytes, captures header fields and forms the key.
// ----------------------------------------------------------------------------
module fkh_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             last,
  input  logic             mode_sel,
  output logic             push,
  output fkh_pkg::fkh_key_t key
);

  localparam logic [6:0]  COUNT_MAX   = 7'd127;
  localparam logic [6:0]  OFS_ET_HI   = 7'd12;
  localparam logic [6:0]  OFS_ET_LO   = 7'd13;
  localparam logic [6:0]  OFS_IP      = 7'd14;
  localparam logic [6:0]  OFS_PROTO   = 7'd23;
  localparam logic [6:0]  OFS_SRC_LO  = 7'd26;
  localparam logic [6:0]  OFS_SRC_HI  = 7'd29;
  localparam logic [6:0]  OFS_DST_LO  = 7'd30;
  localparam logic [6:0]  OFS_DST_HI  = 7'd33;
  localparam logic [6:0]  PORT_END    = 7'd18;
  localparam logic [6:0]  MIN_FRAME   = 7'd34;
  localparam logic [15:0] ETH_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;

  logic [6:0]  byte_count,       byte_count_next;
  logic [15:0] ether_type_word,  ether_type_word_next;
  logic [5:0]  header_bytes,     header_bytes_next;
  logic [7:0]  protocol_byte,    protocol_byte_next;
  logic [31:0] source_address,   source_address_next;
  logic [31:0] dest_address,     dest_address_next;
  logic [15:0] source_port_word, source_port_word_next;
  logic [15:0] dest_port_word,   dest_port_word_next;

  logic       live;
  logic [6:0] ip_ofs;
  logic [6:0] port_rel;
  logic       port_hit;
  logic       ports_ok;

  always_comb begin
    live     = (byte_count != COUNT_MAX);
    ip_ofs   = byte_count - OFS_IP;

    byte_count_next       = byte_count;
    ether_type_word_next  = ether_type_word;
    header_bytes_next     = header_bytes;
    protocol_byte_next    = protocol_byte;
    source_address_next   = source_address;
    dest_address_next     = dest_address;
    source_port_word_next = source_port_word;
    dest_port_word_next   = dest_port_word;

    if (live) begin
      if (byte_count == OFS_ET_HI) ether_type_word_next[15:8] = data_byte;
      if (byte_count == OFS_ET_LO) ether_type_word_next[7:0]  = data_byte;
      if (byte_count == OFS_IP)    header_bytes_next = {data_byte[3:0], 2'b00};
      if (byte_count == OFS_PROTO) protocol_byte_next = data_byte;
      if (byte_count >= OFS_SRC_LO && byte_count <= OFS_SRC_HI) begin
        source_address_next = {source_address[23:0], data_byte};
      end
      if (byte_count >= OFS_DST_LO && byte_count <= OFS_DST_HI) begin
        dest_address_next = {dest_address[23:0], data_byte};
      end
      byte_count_next = byte_count + 7'd1;
    end

    // port bytes sit right after the ipv4 header, at 14 + ihl*4
    port_rel = ip_ofs - {1'b0, header_bytes_next};
    port_hit = live && (byte_count >= OFS_IP) && (ip_ofs >= {1'b0, header_bytes_next})
               && (port_rel < 7'd4);
    if (port_hit) begin
      case (port_rel[1:0])
        2'd0:    source_port_word_next[15:8] = data_byte;
        2'd1:    source_port_word_next[7:0]  = data_byte;
        2'd2:    dest_port_word_next[15:8]   = data_byte;
        default: dest_port_word_next[7:0]    = data_byte;
      endcase
    end

    ports_ok = ((PORT_END + {1'b0, header_bytes_next}) <= byte_count_next) &&
               (protocol_byte_next == PROTO_TCP || protocol_byte_next == PROTO_UDP);

    key.src_addr = source_address_next;
    key.dst_addr = dest_address_next;
    key.l4_sport = ports_ok ? source_port_word_next : 16'd0;
    key.l4_dport = ports_ok ? dest_port_word_next : 16'd0;
    key.proto    = protocol_byte_next;
    if (byte_count_next < MIN_FRAME) begin
      key.key_len = fkh_pkg::KEY_LEN_NONE;
    end else if (mode_sel) begin
      key.key_len = fkh_pkg::KEY_LEN_PAIR;
    end else if (ether_type_word_next == ETH_IPV4) begin
      key.key_len = fkh_pkg::KEY_LEN_TUPLE;
    end else begin
      key.key_len = fkh_pkg::KEY_LEN_NONE;
    end
  end

  assign push = accept && last;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_count       <= '0;
      ether_type_word  <= '0;
      header_bytes     <= '0;
      protocol_byte    <= '0;
      source_address   <= '0;
      dest_address     <= '0;
      source_port_word <= '0;
      dest_port_word   <= '0;
    end else if (accept) begin
      byte_count       <= byte_count_next;
      ether_type_word  <= ether_type_word_next;
      header_bytes     <= header_bytes_next;
      protocol_byte    <= protocol_byte_next;
      source_address   <= source_address_next;
      dest_address     <= dest_address_next;
      source_port_word <= source_port_word_next;
      dest_port_word   <= dest_port_word_next;
    end
  end

endmodule

### hdl/fkh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkh_queue
// Small key queue between the parser and the hash engine.
// ----------------------------------------------------------------------------
module fkh_queue #(
  parameter int DEPTH = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  fkh_pkg::fkh_key_t         push_key,
  input  logic                      pop,
  output fkh_pkg::fkh_key_t         head,
  output fkh_pkg::fkh_queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  fkh_pkg::fkh_key_t entry [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign head         = entry[rd_ptr];
  assign status.full  = (count == CNT_FULL);
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entry[wr_ptr] <= push_key;
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### hdl/fkh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkh_back
// One-at-a-time hash engine, one key byte per cycle, with output register.
// ----------------------------------------------------------------------------
module fkh_back (
  input  logic                      clk,
  input  logic                      rst,
  input  fkh_pkg::fkh_key_t         head,
  input  fkh_pkg::fkh_queue_status_t qstat,
  output logic                      pop,
  output logic [31:0]               flow_hash,
  output logic                      hash_valid,
  input  logic                      hash_stall,
  output logic                      engine_idle
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MIX  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state;
  fkh_pkg::fkh_key_t key;
  logic [3:0]        key_position;
  logic [31:0]       hash_accumulator;

  logic [7:0]  key_byte;
  logic [31:0] mix_a, mix_b, mix_c;
  logic [31:0] fin_a, fin_b, fin_c;
  logic        out_free;

  always_comb begin
    case (key_position)
      4'd0:    key_byte = key.src_addr[31:24];
      4'd1:    key_byte = key.src_addr[23:16];
      4'd2:    key_byte = key.src_addr[15:8];
      4'd3:    key_byte = key.src_addr[7:0];
      4'd4:    key_byte = key.dst_addr[31:24];
      4'd5:    key_byte = key.dst_addr[23:16];
      4'd6:    key_byte = key.dst_addr[15:8];
      4'd7:    key_byte = key.dst_addr[7:0];
      4'd8:    key_byte = key.l4_sport[7:0];
      4'd9:    key_byte = key.l4_sport[15:8];
      4'd10:   key_byte = key.l4_dport[7:0];
      4'd11:   key_byte = key.l4_dport[15:8];
      4'd12:   key_byte = key.proto;
      default: key_byte = 8'd0;
    endcase

    mix_a = hash_accumulator + {24'd0, key_byte};
    mix_b = mix_a + (mix_a << 10);
    mix_c = mix_b ^ (mix_b >> 6);

    fin_a = hash_accumulator + (hash_accumulator << 3);
    fin_b = fin_a ^ (fin_a >> 11);
    fin_c = fin_b + (fin_b << 15);
  end

  assign pop         = (state == ST_IDLE) && !qstat.empty;
  assign out_free    = !hash_valid || !hash_stall;
  assign engine_idle = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hash_valid <= 1'b0;
    end else begin
      if (hash_valid && !hash_stall && state != ST_DONE) begin
        hash_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            key              <= head;
            key_position     <= 4'd0;
            hash_accumulator <= 32'd0;
            state <= (head.key_len == fkh_pkg::KEY_LEN_NONE) ? ST_DONE : ST_MIX;
          end
        end
        ST_MIX: begin
          hash_accumulator <= mix_c;
          key_position     <= key_position + 4'd1;
          if (key_position == key.key_len - 4'd1) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          hash_accumulator <= fin_c;
          state            <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            flow_hash  <= (key.key_len == fkh_pkg::KEY_LEN_NONE) ? 32'd0 : hash_accumulator;
            hash_valid <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### hdl/ipv4_flow_key_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_flow_key_hash
// Flow hash over an Ethernet/IPv4 byte stream: parser, key queue, hash engine.
// ----------------------------------------------------------------------------
// throughput: one frame byte per cycle while data_stall is low; the engine works
//   on one key at a time and takes the next key from the queue only when idle
// flow_hash follows the last byte after any wait on the key queue and the
//   engine's mix, finish and done states; a zero result skips mix and finish
// data_stall rises only when the key queue is full
// reset clears frame state, mode, the key queue and any pending hash
module ipv4_flow_key_hash #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        hash_valid,
  input  logic        hash_stall,
  output logic [31:0] flow_hash,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        mode
);

  logic                       mode_sel;
  logic                       data_accept;
  logic                       push;
  logic                       pop;
  logic                       engine_idle;
  fkh_pkg::fkh_key_t          push_key;
  fkh_pkg::fkh_key_t          head;
  fkh_pkg::fkh_queue_status_t qstat;

  assign cfg_ready   = 1'b1;
  assign data_stall  = qstat.full;
  assign data_accept = data_valid && !data_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_sel <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode_sel <= mode;
    end
  end

  fkh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (data_accept),
    .data_byte (data_byte),
    .last      (last),
    .mode_sel  (mode_sel),
    .push      (push),
    .key       (push_key)
  );

  fkh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_key (push_key),
    .pop      (pop),
    .head     (head),
    .status   (qstat)
  );

  fkh_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .flow_hash   (flow_hash),
    .hash_valid  (hash_valid),
    .hash_stall  (hash_stall),
    .engine_idle (engine_idle)
  );

  a_engine_takes_key: assert property (@(posedge clk) disable iff (rst)
    (!qstat.empty && engine_idle) |=> !engine_idle)
    else $error("engine did not take a queued key");

  a_hash_from_engine: assert property (@(posedge clk) disable iff (rst)
    $rose(hash_valid) |-> $past(!engine_idle))
    else $error("hash presented without engine activity");

  a_mode_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> (mode_sel == $past(mode)))
    else $error("mode transfer not captured");

endmodule
